// ----- rtl/cpfw_pkg.sv -----
// ============================================================================
// cpfw_pkg: credit pool shared definitions
// Sizes, command and status codes, sequencer states and the structs that run
// between the pool controller, its subtract/add unit and the waiter store.
// ============================================================================
package cpfw_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int UNIT_BITS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int GRANT_W     = $clog2(MAX_RESULTS + 1);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 4;
    localparam int TAG_W       = 8;

    typedef logic [UNIT_BITS-1:0] t_units;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [TAG_W-1:0]     t_tag;
    typedef logic [GRANT_W-1:0]   t_ngrant;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_GROW    = 3'd2,
        CMD_SHRINK  = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_NEVER      = 4'd2,
        ST_WOULD_WAIT = 4'd3,
        ST_QUEUE_FULL = 4'd4,
        ST_RELEASED   = 4'd5,
        ST_ADJUSTED   = 4'd6,
        ST_RETRY      = 4'd7,
        ST_QUERY      = 4'd8
    } t_status;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } t_alu_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RES_TOT,
        S_RES_FREE,
        S_REL_ROOM,
        S_REL_MIN,
        S_REL_ADD,
        S_GRO_ROOM,
        S_GRO_MIN,
        S_GRO_TOT,
        S_GRO_FREE,
        S_SCAN,
        S_SHR_MAX,
        S_SHR_CAP,
        S_SHR_FREE,
        S_SHR_MIN,
        S_SHR_SUBF,
        S_SHR_SUBT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_alu_op op;
        t_units  a;
        t_units  b;
    } t_alu_req;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_units need;
        t_tag   tag;
    } t_q_wr;

    typedef struct packed {
        t_status status;
        t_tag    grant_id;
        t_units  granted;
        t_units  adjusted;
        t_units  unused;
    } t_result;

    function automatic t_result mk_result(t_status st, t_tag id, t_units gu,
                                          t_units au, t_units uu);
        t_result r;
        r.status   = st;
        r.grant_id = id;
        r.granted  = gu;
        r.adjusted = au;
        r.unused   = uu;
        return r;
    endfunction

endpackage

// ----- rtl/credit_pool_with_first_fit_waiters.sv -----
// ============================================================================
// credit_pool_with_first_fit_waiters: unit pool with an ordered waiter queue
// Counting pool (free and total units) plus up to QUEUE_DEPTH waiting
// reservations, served first fit in arrival order.
// ============================================================================
// One command is taken per transfer and is worked on alone; o_in_stall stays
// high until its last result sits in the output register. Every step goes
// through a single add/subtract unit, one operation per cycle. Release and
// grow walk the queued waiters: the waiter walk reads one entry per cycle
// from the waiter store, unless a grant waits for the output register, and
// compacts the queue in place as grants are made. A non-zero shrink walks
// the waiters to find the largest waiting need and may report retry. A
// stalled output holds the command up. Commands 5 to 7 are taken and
// dropped without a result.
// Every result transfer carries o_last on the final result of its command.
// ============================================================================
module credit_pool_with_first_fit_waiters import cpfw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  t_units              i_amount,
    input  t_tag                i_requester_id,
    input  logic                i_wait_allowed,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output t_tag                o_grant_id,
    output t_units              o_granted_units,
    output t_units              o_adjusted_units,
    output t_units              o_unused_units,
    output logic                o_last
);

    localparam t_units UMAX = {UNIT_BITS{1'b1}};

    // control state
    t_state  r_state, n_state;
    t_units  r_free, n_free;
    t_units  r_total, n_total;
    t_cnt    r_cnt, n_cnt;
    t_cnt    r_ridx, n_ridx;       // entry held in the store's read register
    t_cnt    r_widx, n_widx;       // compaction write pointer
    t_ngrant r_ngrant, n_ngrant;
    logic    r_pend_vld, n_pend_vld;
    logic    r_is_grow, n_is_grow;
    logic    r_out_vld, n_out_vld;

    // payload
    t_units  r_amt, n_amt;
    t_tag    r_id, n_id;
    logic    r_wait, n_wait;
    t_units  r_tmp, n_tmp;         // room, largest need, cap
    t_units  r_adj, n_adj;         // units added by grow
    t_units  r_grab, n_grab;
    t_result r_pend, n_pend;       // held back until we know if it is last
    t_result r_out, n_out;
    logic    r_out_last, n_out_last;

    t_alu_req alu_req;
    t_units   alu_res;
    logic     alu_borrow;
    t_q_wr    q_wr;
    t_units   rd_need;
    t_tag     rd_tag;
    logic     out_ok;
    logic     fit;

    cpfw_alu u_alu (
        .i_req    (alu_req),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    cpfw_queue u_queue (
        .i_clk     (i_clk),
        .i_wr      (q_wr),
        .i_raddr   (n_ridx[ADDR_W-1:0]),
        .o_rd_need (rd_need),
        .o_rd_tag  (rd_tag)
    );

    // output register may take a new result when empty or being drained
    assign out_ok = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_total    = r_total;
        n_cnt      = r_cnt;
        n_ridx     = r_ridx;
        n_widx     = r_widx;
        n_ngrant   = r_ngrant;
        n_pend_vld = r_pend_vld;
        n_is_grow  = r_is_grow;
        n_amt      = r_amt;
        n_id       = r_id;
        n_wait     = r_wait;
        n_tmp      = r_tmp;
        n_adj      = r_adj;
        n_grab     = r_grab;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && i_out_stall;
        alu_req    = '{op: ALU_SUB, a: r_free, b: r_amt};
        q_wr       = '{en: 1'b0, addr: r_cnt[ADDR_W-1:0], need: r_amt, tag: r_id};
        fit        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_amt      = i_amount;
                    n_id       = i_requester_id;
                    n_wait     = i_wait_allowed;
                    n_ridx     = '0;
                    n_widx     = '0;
                    n_ngrant   = '0;
                    n_pend_vld = 1'b0;
                    n_tmp      = '0;
                    n_adj      = '0;
                    unique case (t_cmd'(i_cmd))
                        CMD_RESERVE: n_state = S_RES_TOT;
                        CMD_RELEASE: begin
                            n_is_grow = 1'b0;
                            n_state   = S_REL_ROOM;
                        end
                        CMD_GROW: begin
                            n_is_grow = 1'b1;
                            n_state   = S_GRO_ROOM;
                        end
                        CMD_SHRINK: begin
                            if (i_amount == '0) begin
                                n_pend  = mk_result(ST_ADJUSTED, '0, '0, '0, '0);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SHR_MAX;
                            end
                        end
                        CMD_QUERY: begin
                            n_pend  = mk_result(ST_QUERY, '0, '0, '0,
                                                (r_cnt != '0) ? '0 : r_free);
                            n_state = S_EMIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // reserve: beyond total, then fits now, then queue
            S_RES_TOT: begin
                alu_req = '{op: ALU_SUB, a: r_total, b: r_amt};
                if (alu_borrow) begin
                    n_pend  = mk_result(ST_NEVER, r_id, '0, '0, '0);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RES_FREE;
                end
            end
            S_RES_FREE: begin
                alu_req = '{op: ALU_SUB, a: r_free, b: r_amt};
                n_state = S_EMIT;
                if (!alu_borrow) begin
                    n_free = alu_res;
                    n_pend = mk_result(ST_GRANTED, r_id, r_amt, '0, '0);
                end else if (!r_wait) begin
                    n_pend = mk_result(ST_WOULD_WAIT, r_id, '0, '0, '0);
                end else if (r_cnt == CNT_W'(QUEUE_DEPTH)) begin
                    n_pend = mk_result(ST_QUEUE_FULL, r_id, '0, '0, '0);
                end else begin
                    q_wr.en = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_pend  = mk_result(ST_QUEUED, r_id, '0, '0, '0);
                end
            end

            // release: free += min(amount, total - free)
            S_REL_ROOM: begin
                alu_req = '{op: ALU_SUB, a: r_total, b: r_free};
                n_tmp   = alu_res;
                n_state = S_REL_MIN;
            end
            S_REL_MIN: begin
                alu_req = '{op: ALU_SUB, a: r_tmp, b: r_amt};
                if (!alu_borrow) begin
                    n_tmp = r_amt;
                end
                n_state = S_REL_ADD;
            end
            S_REL_ADD: begin
                alu_req = '{op: ALU_ADD, a: r_free, b: r_tmp};
                n_free  = alu_res;
                n_state = S_SCAN;
            end

            // grow: add = min(amount, UMAX - total) to both counts
            S_GRO_ROOM: begin
                alu_req = '{op: ALU_SUB, a: UMAX, b: r_total};
                n_tmp   = alu_res;
                n_state = S_GRO_MIN;
            end
            S_GRO_MIN: begin
                alu_req = '{op: ALU_SUB, a: r_tmp, b: r_amt};
                n_adj   = alu_borrow ? r_tmp : r_amt;
                n_state = S_GRO_TOT;
            end
            S_GRO_TOT: begin
                alu_req = '{op: ALU_ADD, a: r_total, b: r_adj};
                n_total = alu_res;
                n_state = S_GRO_FREE;
            end
            S_GRO_FREE: begin
                alu_req = '{op: ALU_ADD, a: r_free, b: r_adj};
                n_free  = alu_res;
                n_state = S_SCAN;
            end

            // first-fit walk; granted entries drop out, the rest slide down
            S_SCAN: begin
                if (r_ridx == r_cnt) begin
                    n_cnt = r_widx;
                    if (!r_pend_vld) begin
                        n_pend = r_is_grow ?
                                 mk_result(ST_ADJUSTED, '0, '0, r_adj, '0) :
                                 mk_result(ST_RELEASED, '0, '0, '0, '0);
                    end
                    n_state = S_EMIT;
                end else begin
                    alu_req = '{op: ALU_SUB, a: r_free, b: rd_need};
                    fit     = !alu_borrow && (r_ngrant < GRANT_W'(MAX_RESULTS));
                    if (fit) begin
                        if (!r_pend_vld || out_ok) begin
                            n_free = alu_res;
                            if (r_pend_vld) begin
                                n_out      = r_pend;
                                n_out_last = 1'b0;
                                n_out_vld  = 1'b1;
                            end
                            n_pend     = mk_result(ST_GRANTED, rd_tag, rd_need, r_adj, '0);
                            n_pend_vld = 1'b1;
                            n_ngrant   = r_ngrant + 1'b1;
                            n_ridx     = r_ridx + 1'b1;
                        end
                    end else begin
                        q_wr     = '{en: 1'b1, addr: r_widx[ADDR_W-1:0],
                                     need: rd_need, tag: rd_tag};
                        n_widx   = r_widx + 1'b1;
                        n_ridx   = r_ridx + 1'b1;
                    end
                end
            end

            // shrink: grab = min(amount, free, total - largest need)
            S_SHR_MAX: begin
                if (r_ridx == r_cnt) begin
                    n_state = S_SHR_CAP;
                end else begin
                    alu_req = '{op: ALU_SUB, a: r_tmp, b: rd_need};
                    if (alu_borrow) begin
                        n_tmp = rd_need;
                    end
                    n_ridx = r_ridx + 1'b1;
                end
            end
            S_SHR_CAP: begin
                alu_req = '{op: ALU_SUB, a: r_total, b: r_tmp};
                n_tmp   = alu_borrow ? '0 : alu_res;
                n_state = S_SHR_FREE;
            end
            S_SHR_FREE: begin
                alu_req = '{op: ALU_SUB, a: r_free, b: r_amt};
                n_grab  = alu_borrow ? r_free : r_amt;
                n_state = S_SHR_MIN;
            end
            S_SHR_MIN: begin
                alu_req = '{op: ALU_SUB, a: r_grab, b: r_tmp};
                if (!alu_borrow) begin
                    n_grab = r_tmp;
                end
                n_state = S_SHR_SUBF;
            end
            S_SHR_SUBF: begin
                if (r_grab == '0) begin
                    n_pend  = mk_result(ST_RETRY, '0, '0, '0, '0);
                    n_state = S_EMIT;
                end else begin
                    alu_req = '{op: ALU_SUB, a: r_free, b: r_grab};
                    n_free  = alu_res;
                    n_state = S_SHR_SUBT;
                end
            end
            S_SHR_SUBT: begin
                alu_req = '{op: ALU_SUB, a: r_total, b: r_grab};
                n_total = alu_res;
                n_pend  = mk_result(ST_ADJUSTED, '0, '0, r_grab, '0);
                n_state = S_EMIT;
            end

            // final result of the command
            S_EMIT: begin
                if (out_ok) begin
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_free     <= '0;
            r_total    <= '0;
            r_cnt      <= '0;
            r_ridx     <= '0;
            r_widx     <= '0;
            r_ngrant   <= '0;
            r_pend_vld <= 1'b0;
            r_is_grow  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free     <= n_free;
            r_total    <= n_total;
            r_cnt      <= n_cnt;
            r_ridx     <= n_ridx;
            r_widx     <= n_widx;
            r_ngrant   <= n_ngrant;
            r_pend_vld <= n_pend_vld;
            r_is_grow  <= n_is_grow;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt      <= n_amt;
        r_id       <= n_id;
        r_wait     <= n_wait;
        r_tmp      <= n_tmp;
        r_adj      <= n_adj;
        r_grab     <= n_grab;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_grant_id       = r_out.grant_id;
    assign o_granted_units  = r_out.granted;
    assign o_adjusted_units = r_out.adjusted;
    assign o_unused_units   = r_out.unused;
    assign o_last           = r_out_last;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_free_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_total)
        else $error("free units exceed total units");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("waiter count beyond queue depth");

    a_scan_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_widx <= r_ridx && r_ridx <= r_cnt))
        else $error("compaction pointer passed read pointer");

    a_grant_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ngrant <= GRANT_W'(MAX_RESULTS))
        else $error("too many grants for one command");

    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_ok) |=> (o_out_valid && o_last))
        else $error("final result not presented with last");

endmodule

// ----- rtl/cpfw_alu.sv -----
// ============================================================================
// cpfw_alu: shared subtract/add unit
// One UNIT_BITS wide add or subtract per cycle; the borrow doubles as a
// less-than compare.
// ============================================================================
module cpfw_alu import cpfw_pkg::*; (
    input  t_alu_req i_req,
    output t_units   o_res,
    output logic     o_borrow
);

    logic [UNIT_BITS:0] w_sum;

    always_comb begin
        if (i_req.op == ALU_ADD) begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    assign o_res    = w_sum[UNIT_BITS-1:0];
    assign o_borrow = w_sum[UNIT_BITS];

endmodule

// ----- rtl/cpfw_queue.sv -----
// ============================================================================
// cpfw_queue: waiter store
// Need and tag per waiter; one write port, one read port with registered
// read data.
// ============================================================================
module cpfw_queue import cpfw_pkg::*; (
    input  logic   i_clk,
    input  t_q_wr  i_wr,
    input  t_addr  i_raddr,
    output t_units o_rd_need,
    output t_tag   o_rd_tag
);

    t_units r_need_mem [QUEUE_DEPTH];
    t_tag   r_tag_mem  [QUEUE_DEPTH];
    t_units r_rd_need;
    t_tag   r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_need_mem[i_wr.addr] <= i_wr.need;
            r_tag_mem[i_wr.addr]  <= i_wr.tag;
        end
        r_rd_need <= r_need_mem[i_raddr];
        r_rd_tag  <= r_tag_mem[i_raddr];
    end

    assign o_rd_need = r_rd_need;
    assign o_rd_tag  = r_rd_tag;

endmodule
